### src/binary_min_heap_queue_defines.svh
// ----------------------------------------------------------------------------
// binary_min_heap_queue_defines.svh
// Assertion macros used by the heap queue checker.
// ----------------------------------------------------------------------------
`ifndef BINARY_MIN_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define BHQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held
`define BHQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/bhq_pkg.sv
// ----------------------------------------------------------------------------
// bhq_pkg
// Sizes, command and status codes and shared types of the heap queue.
// ----------------------------------------------------------------------------
package bhq_pkg;

  // Heap sizing
  localparam int CAPACITY = 64;
  localparam int KEY_BITS = 16;
  localparam int ID_BITS  = 8;

  localparam int ADDR_W  = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int CHILD_W = ADDR_W + 2;
  localparam int ENTRY_W = KEY_BITS + ID_BITS;

  // Port field widths
  localparam int CMD_W  = 2;
  localparam int ST_W   = 2;
  localparam int KEY_W  = 16;
  localparam int ID_W   = 8;
  localparam int FILL_W = 7;

  // Command codes (the fourth code is ignored)
  localparam logic [CMD_W-1:0] CMD_INSERT = CMD_W'(0);
  localparam logic [CMD_W-1:0] CMD_POP    = CMD_W'(1);
  localparam logic [CMD_W-1:0] CMD_PEEK   = CMD_W'(2);

  // Result status
  typedef enum logic [ST_W-1:0] {
    ST_OK,
    ST_FULL,
    ST_EMPTY
  } status_t;

  // Compare unit verdict: take_b outranks take_a
  typedef struct packed {
    logic take_a;
    logic take_b;
  } pick_t;

endpackage

### src/bhq_if.sv
// ----------------------------------------------------------------------------
// bhq_if
// Request and response channels of the heap queue (valid/ready).
// ----------------------------------------------------------------------------
interface bhq_req_if;
  logic                        valid;
  logic                        ready;
  logic [bhq_pkg::CMD_W-1:0]   command;
  logic [bhq_pkg::KEY_W-1:0]   key;
  logic [bhq_pkg::ID_W-1:0]    entry_id;

  modport source(output valid, command, key, entry_id, input ready);
  modport sink(input valid, command, key, entry_id, output ready);
endinterface

interface bhq_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [bhq_pkg::ST_W-1:0]    status;
  logic [bhq_pkg::KEY_W-1:0]   out_key;
  logic [bhq_pkg::ID_W-1:0]    out_id;
  logic [bhq_pkg::FILL_W-1:0]  fill;

  modport source(output valid, status, out_key, out_id, fill, input ready);
  modport sink(input valid, status, out_key, out_id, fill, output ready);
endinterface

### src/bhq_ram.sv
// ----------------------------------------------------------------------------
// bhq_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write first-come, read returns the old word on a collision
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

### src/bhq_cmp.sv
// ----------------------------------------------------------------------------
// bhq_cmp
// Shared key compare unit: picks the strictly smallest of a base key and
// up to two candidates, earlier candidates winning ties.
// ----------------------------------------------------------------------------
module bhq_cmp (
  input  logic [bhq_pkg::KEY_BITS-1:0] base_key,
  input  logic [bhq_pkg::KEY_BITS-1:0] a_key,
  input  logic                         a_ok,
  input  logic [bhq_pkg::KEY_BITS-1:0] b_key,
  input  logic                         b_ok,
  output bhq_pkg::pick_t               pick
);

  logic                         take_a;
  logic [bhq_pkg::KEY_BITS-1:0] best_key;

  // Candidate a first, then b against the running best
  assign take_a      = a_ok && (a_key < base_key);
  assign best_key    = take_a ? a_key : base_key;
  assign pick.take_a = take_a;
  assign pick.take_b = b_ok && (b_key < best_key);

endmodule

### src/binary_min_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Binary min-heap priority queue held in one RAM, walked by a sequencer.
// ----------------------------------------------------------------------------
// Each request (insert, pop minimum, peek minimum) gives one response. The
// block handles one request at a time; ready is high only while idle. The
// heap lives in a single RAM with one write and one registered read port,
// and a single key comparator decides each step. An insert reads each
// parent in turn while the new entry rises; a pop reads the root, then the
// last entry, then both children for each level the moved entry sinks.
// Peek, a pop of the only entry, a dropped insert, a pop or peek on an
// empty heap and an unused command finish without any sifting. The RAM
// read port paces the work: one read per parent step, two per child step.
// Ready returns with the response. The response sits in an output
// register; while an earlier response is still waiting downstream, the
// sequencer holds in its last state and ready stays low. Equal keys are
// never swapped. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module binary_min_heap_queue (
  input  logic          clk,
  input  logic          rst_n,
  bhq_req_if.sink       in_req,
  bhq_rsp_if.source     out_rsp
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_ROOT,
    S_LAST,
    S_DN_L,
    S_DN_R,
    S_DN_CMP,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  logic [bhq_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [bhq_pkg::ADDR_W-1:0]   pos_r, pos_nxt;
  logic [bhq_pkg::KEY_BITS-1:0] mov_key_r, mov_key_nxt;
  logic [bhq_pkg::ID_BITS-1:0]  mov_id_r, mov_id_nxt;
  logic [bhq_pkg::KEY_BITS-1:0] left_key_r, left_key_nxt;
  logic [bhq_pkg::ID_BITS-1:0]  left_id_r, left_id_nxt;
  logic                         is_pop_r, is_pop_nxt;
  bhq_pkg::status_t             res_status_r, res_status_nxt;
  logic [bhq_pkg::KEY_BITS-1:0] res_key_r, res_key_nxt;
  logic [bhq_pkg::ID_BITS-1:0]  res_id_r, res_id_nxt;

  logic                         out_valid_r, out_valid_nxt;
  bhq_pkg::status_t             out_status_r, out_status_nxt;
  logic [bhq_pkg::KEY_W-1:0]    out_key_r, out_key_nxt;
  logic [bhq_pkg::ID_W-1:0]     out_id_r, out_id_nxt;
  logic [bhq_pkg::FILL_W-1:0]   out_fill_r, out_fill_nxt;

  // RAM port signals
  logic                         wr_en;
  logic [bhq_pkg::ADDR_W-1:0]   wr_addr;
  logic [bhq_pkg::ENTRY_W-1:0]  wr_data;
  logic [bhq_pkg::ADDR_W-1:0]   rd_addr;
  logic [bhq_pkg::ENTRY_W-1:0]  rd_data;
  logic [bhq_pkg::KEY_BITS-1:0] rd_key;
  logic [bhq_pkg::ID_BITS-1:0]  rd_id;

  // Heap index arithmetic
  logic [bhq_pkg::CHILD_W-1:0]  lc, rc, cnt_ext;
  logic                         lc_ok, rc_ok;
  logic [bhq_pkg::ADDR_W-1:0]   par;
  logic                         full;

  // Compare unit operands
  logic [bhq_pkg::KEY_BITS-1:0] cmp_base;
  logic                         cmp_a_ok;
  bhq_pkg::pick_t               pick;

  assign rd_key = rd_data[bhq_pkg::ENTRY_W-1:bhq_pkg::ID_BITS];
  assign rd_id  = rd_data[bhq_pkg::ID_BITS-1:0];

  assign lc      = {1'b0, pos_r, 1'b1};
  assign rc      = lc + bhq_pkg::CHILD_W'(1);
  assign cnt_ext = bhq_pkg::CHILD_W'(count_r);
  assign lc_ok   = lc < cnt_ext;
  assign rc_ok   = rc < cnt_ext;
  assign par     = bhq_pkg::ADDR_W'((pos_r - bhq_pkg::ADDR_W'(1)) >> 1);
  assign full    = count_r >= bhq_pkg::CNT_W'(bhq_pkg::CAPACITY);

  // Sift up: does the moving entry beat its parent; sift down: which child wins
  assign cmp_base = (state_r == S_UP_CMP) ? rd_key : mov_key_r;
  assign cmp_a_ok = (state_r == S_UP_CMP) || (state_r == S_DN_CMP);

  bhq_cmp u_cmp (
    .base_key (cmp_base),
    .a_key    ((state_r == S_UP_CMP) ? mov_key_r : left_key_r),
    .a_ok     (cmp_a_ok),
    .b_key    (rd_key),
    .b_ok     ((state_r == S_DN_CMP) && rc_ok),
    .pick     (pick)
  );

  bhq_ram #(
    .WIDTH (bhq_pkg::ENTRY_W),
    .DEPTH (bhq_pkg::CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_req.ready    = (state_r == S_IDLE);
  assign out_rsp.valid   = out_valid_r;
  assign out_rsp.status  = out_status_r;
  assign out_rsp.out_key = out_key_r;
  assign out_rsp.out_id  = out_id_r;
  assign out_rsp.fill    = out_fill_r;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    mov_key_nxt    = mov_key_r;
    mov_id_nxt     = mov_id_r;
    left_key_nxt   = left_key_r;
    left_id_nxt    = left_id_r;
    is_pop_nxt     = is_pop_r;
    res_status_nxt = res_status_r;
    res_key_nxt    = res_key_r;
    res_id_nxt     = res_id_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_id_nxt     = out_id_r;
    out_fill_nxt   = out_fill_r;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = pos_r;
    wr_data        = {mov_key_r, mov_id_r};

    // Response taken downstream
    if (out_valid_r && out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        // Root is read every idle cycle, ready for pop or peek
        if (in_req.valid) begin
          res_status_nxt = bhq_pkg::ST_OK;
          res_key_nxt    = '0;
          res_id_nxt     = '0;
          is_pop_nxt     = (in_req.command == bhq_pkg::CMD_POP);
          priority if (in_req.command == bhq_pkg::CMD_INSERT) begin
            if (full) begin
              res_status_nxt = bhq_pkg::ST_FULL;
              state_nxt      = S_DONE;
            end else begin
              mov_key_nxt = in_req.key[bhq_pkg::KEY_BITS-1:0];
              mov_id_nxt  = in_req.entry_id[bhq_pkg::ID_BITS-1:0];
              pos_nxt     = bhq_pkg::ADDR_W'(count_r);
              count_nxt   = count_r + bhq_pkg::CNT_W'(1);
              state_nxt   = S_UP_RD;
            end
          end else if (in_req.command == bhq_pkg::CMD_POP ||
                       in_req.command == bhq_pkg::CMD_PEEK) begin
            if (count_r == '0) begin
              res_status_nxt = bhq_pkg::ST_EMPTY;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_ROOT;
            end
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      S_UP_RD: begin
        if (pos_r == '0) begin
          wr_en     = 1'b1;
          state_nxt = S_DONE;
        end else begin
          rd_addr   = par;
          state_nxt = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        // Parent strictly greater: it moves down into the hole
        wr_en = 1'b1;
        if (pick.take_a) begin
          wr_data   = rd_data;
          pos_nxt   = par;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_ROOT: begin
        res_key_nxt = rd_key;
        res_id_nxt  = rd_id;
        if (!is_pop_r) begin
          state_nxt = S_DONE;
        end else begin
          count_nxt = count_r - bhq_pkg::CNT_W'(1);
          if (count_r == bhq_pkg::CNT_W'(1)) begin
            state_nxt = S_DONE;
          end else begin
            rd_addr   = bhq_pkg::ADDR_W'(count_r - bhq_pkg::CNT_W'(1));
            state_nxt = S_LAST;
          end
        end
      end

      S_LAST: begin
        // Last entry becomes the moving entry at the root
        mov_key_nxt = rd_key;
        mov_id_nxt  = rd_id;
        pos_nxt     = '0;
        state_nxt   = S_DN_L;
      end

      S_DN_L: begin
        if (!lc_ok) begin
          wr_en     = 1'b1;
          state_nxt = S_DONE;
        end else begin
          rd_addr   = lc[bhq_pkg::ADDR_W-1:0];
          state_nxt = S_DN_R;
        end
      end

      S_DN_R: begin
        left_key_nxt = rd_key;
        left_id_nxt  = rd_id;
        if (rc_ok) begin
          rd_addr = rc[bhq_pkg::ADDR_W-1:0];
        end
        state_nxt = S_DN_CMP;
      end

      S_DN_CMP: begin
        // Winning child moves up into the hole
        wr_en = 1'b1;
        priority if (pick.take_b) begin
          wr_data   = rd_data;
          pos_nxt   = rc[bhq_pkg::ADDR_W-1:0];
          state_nxt = S_DN_L;
        end else if (pick.take_a) begin
          wr_data   = {left_key_r, left_id_r};
          pos_nxt   = lc[bhq_pkg::ADDR_W-1:0];
          state_nxt = S_DN_L;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        // Load the output register once it is free
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_key_nxt    = bhq_pkg::KEY_W'(res_key_r);
          out_id_nxt     = bhq_pkg::ID_W'(res_id_r);
          out_fill_nxt   = bhq_pkg::FILL_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end
    endcase
  end

  // State and registered outputs; payload registers take no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r        <= pos_nxt;
    mov_key_r    <= mov_key_nxt;
    mov_id_r     <= mov_id_nxt;
    left_key_r   <= left_key_nxt;
    left_id_r    <= left_id_nxt;
    is_pop_r     <= is_pop_nxt;
    res_status_r <= res_status_nxt;
    res_key_r    <= res_key_nxt;
    res_id_r     <= res_id_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_id_r     <= out_id_nxt;
    out_fill_r   <= out_fill_nxt;
  end

endmodule

### src/bhq_checker.sv
// ----------------------------------------------------------------------------
// bhq_checker
// Port-level checks of the heap queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "binary_min_heap_queue_defines.svh"

module bhq_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [bhq_pkg::ST_W-1:0]    out_status,
  input logic [bhq_pkg::KEY_W-1:0]   out_key,
  input logic [bhq_pkg::ID_W-1:0]    out_id,
  input logic [bhq_pkg::FILL_W-1:0]  out_fill
);

  // A stalled response stays up
  `BHQ_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "response dropped while stalled")

  // One request at a time: busy right after a request is taken
  `BHQ_ASSERT_NXT(a_busy_after_req, clk, rst_n, in_valid && in_ready, !in_ready, "request taken while busy")

  // Fill never exceeds the heap size
  `BHQ_ASSERT_IMP(a_fill_range, clk, rst_n, out_valid, out_fill <= bhq_pkg::FILL_W'(bhq_pkg::CAPACITY), "fill beyond capacity")

  // A dropped insert only happens on a full heap
  `BHQ_ASSERT_IMP(a_full_fill, clk, rst_n, out_valid && out_status == bhq_pkg::ST_FULL, out_fill == bhq_pkg::FILL_W'(bhq_pkg::CAPACITY) && out_key == '0 && out_id == '0, "full status with room left")

  // Empty status means nothing held and a zero entry
  `BHQ_ASSERT_IMP(a_empty_fill, clk, rst_n, out_valid && out_status == bhq_pkg::ST_EMPTY, out_fill == '0 && out_key == '0 && out_id == '0, "empty status on a non-empty heap")

endmodule

bind binary_min_heap_queue bhq_checker u_bhq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_req.valid),
  .in_ready   (in_req.ready),
  .out_valid  (out_rsp.valid),
  .out_ready  (out_rsp.ready),
  .out_status (out_rsp.status),
  .out_key    (out_rsp.out_key),
  .out_id     (out_rsp.out_id),
  .out_fill   (out_rsp.fill)
);

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the binary min-heap priority queue.
// ----------------------------------------------------------------------------
// A clocked driver feeds insert, pop, peek and unused-command requests from a
// queue that the sequencing block fills. Every accepted request is applied to
// a local heap model, and the response it implies is queued. A clocked
// monitor compares each response, field by field, with the oldest one queued.
// Three traffic phases use different sender and receiver idle rates. One long
// receiver hold-off backs the block up. Between phases the sender waits until
// every response is in.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [bhq_pkg::CMD_W-1:0] CMD_UNUSED = bhq_pkg::CMD_W'(3);
  localparam int HOLD_AT     = 300;   // response count that starts the long stall
  localparam int HOLD_CYCLES = 160;
  localparam int TAIL_CYCLES = 40;

  typedef struct {
    logic [bhq_pkg::CMD_W-1:0] command;
    logic [bhq_pkg::KEY_W-1:0] key;
    logic [bhq_pkg::ID_W-1:0]  entry_id;
  } heap_req_t;

  typedef struct {
    bhq_pkg::status_t           status;
    logic [bhq_pkg::KEY_W-1:0]  out_key;
    logic [bhq_pkg::ID_W-1:0]   out_id;
    logic [bhq_pkg::FILL_W-1:0] fill;
  } heap_rsp_t;

  logic clk;
  logic rst_n;

  bhq_req_if req_ch();
  bhq_rsp_if rsp_ch();

  binary_min_heap_queue u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  // Request and response bookkeeping
  heap_req_t pending_reqs[$];
  heap_rsp_t expected_rsps[$];
  int        send_gap_pct = 27;
  int        recv_gap_pct = 66;
  int        error_count  = 0;
  int        rsp_seen     = 0;
  int        hold_left    = 0;
  bit        hold_done    = 1'b0;

  // Local heap image
  logic [bhq_pkg::KEY_W-1:0] heap_key[bhq_pkg::CAPACITY];
  logic [bhq_pkg::ID_W-1:0]  heap_id[bhq_pkg::CAPACITY];
  int                        heap_count = 0;

  // Coverage tallies for the summary
  int n_insert, n_full, n_pop, n_peek, n_empty, n_unused, peak_fill;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reset
  initial begin
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Hang guard
  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic void heap_swap(int a, int b);
    logic [bhq_pkg::KEY_W-1:0] k;
    logic [bhq_pkg::ID_W-1:0]  d;
    k = heap_key[a];
    d = heap_id[a];
    heap_key[a] = heap_key[b];
    heap_id[a]  = heap_id[b];
    heap_key[b] = k;
    heap_id[b]  = d;
  endfunction

  // Apply one request to the local heap and return the response it implies
  function automatic heap_rsp_t heap_apply(heap_req_t r);
    heap_rsp_t res;
    int        pos;
    int        up;
    int        best;
    int        lc;
    int        rc;
    bit        settled;
    res.status  = bhq_pkg::ST_OK;
    res.out_key = '0;
    res.out_id  = '0;
    case (r.command)
      bhq_pkg::CMD_INSERT: begin
        n_insert++;
        if (heap_count >= bhq_pkg::CAPACITY) begin
          res.status = bhq_pkg::ST_FULL;
          n_full++;
        end else begin
          heap_key[heap_count] = r.key;
          heap_id[heap_count]  = r.entry_id;
          pos = heap_count;
          heap_count++;
          // sift up while the parent is strictly larger
          settled = 1'b0;
          while (pos > 0 && !settled) begin
            up = (pos - 1) / 2;
            if (heap_key[up] > heap_key[pos]) begin
              heap_swap(up, pos);
              pos = up;
            end else begin
              settled = 1'b1;
            end
          end
        end
      end
      bhq_pkg::CMD_POP, bhq_pkg::CMD_PEEK: begin
        if (r.command == bhq_pkg::CMD_POP) n_pop++;
        else n_peek++;
        if (heap_count == 0) begin
          res.status = bhq_pkg::ST_EMPTY;
          n_empty++;
        end else begin
          res.out_key = heap_key[0];
          res.out_id  = heap_id[0];
          if (r.command == bhq_pkg::CMD_POP) begin
            heap_count--;
            heap_key[0] = heap_key[heap_count];
            heap_id[0]  = heap_id[heap_count];
            // sift down: left wins if strictly smaller, then right vs. winner
            pos = 0;
            settled = 1'b0;
            while (pos < heap_count && !settled) begin
              best = pos;
              lc   = 2 * pos + 1;
              rc   = 2 * pos + 2;
              if (lc < heap_count && heap_key[lc] < heap_key[best]) best = lc;
              if (rc < heap_count && heap_key[rc] < heap_key[best]) best = rc;
              if (best == pos) begin
                settled = 1'b1;
              end else begin
                heap_swap(pos, best);
                pos = best;
              end
            end
          end
        end
      end
      default: n_unused++;
    endcase
    if (heap_count > peak_fill) peak_fill = heap_count;
    res.fill = bhq_pkg::FILL_W'(heap_count);
    return res;
  endfunction

  // Request driver
  always @(posedge clk) begin : drive_req
    logic      offer;
    heap_req_t nxt;
    if (!rst_n) begin
      req_ch.valid    <= 1'b0;
      req_ch.command  <= bhq_pkg::CMD_INSERT;
      req_ch.key      <= '0;
      req_ch.entry_id <= '0;
    end else begin
      offer = req_ch.valid;
      if (req_ch.valid && req_ch.ready) begin
        nxt.command  = req_ch.command;
        nxt.key      = req_ch.key;
        nxt.entry_id = req_ch.entry_id;
        expected_rsps.push_back(heap_apply(nxt));
        offer = 1'b0;
      end
      if (!offer && pending_reqs.size() != 0 &&
          $urandom_range(0, 99) >= send_gap_pct) begin
        nxt = pending_reqs.pop_front();
        req_ch.command  <= nxt.command;
        req_ch.key      <= nxt.key;
        req_ch.entry_id <= nxt.entry_id;
        offer = 1'b1;
      end
      req_ch.valid <= offer;
    end
  end

  task automatic field_check(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      error_count++;
    end
  endtask

  // Response monitor and receiver back-pressure
  always @(posedge clk) begin : watch_rsp
    heap_rsp_t want;
    logic      take;
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        rsp_seen++;
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected response: expected none, actual status %0d key %0d",
                   $time, rsp_ch.status, rsp_ch.out_key);
          error_count++;
        end else begin
          want = expected_rsps.pop_front();
          field_check("status", want.status, rsp_ch.status);
          field_check("out_key", want.out_key, rsp_ch.out_key);
          field_check("out_id", want.out_id, rsp_ch.out_id);
          field_check("fill", want.fill, rsp_ch.fill);
        end
        if (rsp_seen == HOLD_AT && !hold_done) begin
          hold_left = HOLD_CYCLES;
          hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else begin
        take = ($urandom_range(0, 99) >= recv_gap_pct);
      end
      rsp_ch.ready <= take;
    end
  end

  task automatic push_req(logic [bhq_pkg::CMD_W-1:0] cmd, logic [bhq_pkg::KEY_W-1:0] k,
                          logic [bhq_pkg::ID_W-1:0] d);
    heap_req_t r;
    r.command  = cmd;
    r.key      = k;
    r.entry_id = d;
    pending_reqs.push_back(r);
  endtask

  // Random request; ins_pct sets the share of inserts
  function automatic heap_req_t rand_req(int ins_pct);
    heap_req_t r;
    int        pick;
    if ($urandom_range(0, 99) < ins_pct) begin
      r.command = bhq_pkg::CMD_INSERT;
    end else begin
      pick = $urandom_range(0, 19);
      if (pick == 0)     r.command = CMD_UNUSED;
      else if (pick < 6) r.command = bhq_pkg::CMD_PEEK;
      else               r.command = bhq_pkg::CMD_POP;
    end
    case ($urandom_range(0, 3))
      0:       r.key = bhq_pkg::KEY_W'($urandom_range(0, 7));   // many equal keys
      1:       r.key = $urandom_range(0, 1) ? '1 : '0;
      2:       r.key = bhq_pkg::KEY_W'($urandom_range(100, 140));
      default: r.key = bhq_pkg::KEY_W'($urandom_range(0, 65535));
    endcase
    r.entry_id = bhq_pkg::ID_W'($urandom_range(0, 255));
    return r;
  endfunction

  task automatic queue_burst(int len, int ins_pct);
    for (int i = 0; i < len; i++) pending_reqs.push_back(rand_req(ins_pct));
  endtask

  // Bursts that lean toward filling, draining or holding the level
  task automatic queue_random(int n);
    int left;
    int len;
    left = n;
    while (left > 0) begin
      len = $urandom_range(20, 90);
      if (len > left) len = left;
      case ($urandom_range(0, 2))
        0:       queue_burst(len, 85);
        1:       queue_burst(len, 25);
        default: queue_burst(len, 55);
      endcase
      left -= len;
    end
  endtask

  // Sender pauses here until every response is back
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_ch.valid || expected_rsps.size() != 0)
      @(negedge clk);
  endtask

  // Test sequence
  initial begin
    n_insert = 0; n_full = 0; n_pop = 0; n_peek = 0;
    n_empty = 0; n_unused = 0; peak_fill = 0;
    @(posedge rst_n);
    @(negedge clk);

    // empty heap corners and the ignored command
    push_req(bhq_pkg::CMD_PEEK, '0, '0);
    push_req(bhq_pkg::CMD_POP, '0, '0);
    push_req(CMD_UNUSED, '1, '1);
    // key and id extremes, equal keys at both ends of the range
    push_req(bhq_pkg::CMD_INSERT, '1, '1);
    push_req(bhq_pkg::CMD_INSERT, '0, '0);
    push_req(bhq_pkg::CMD_INSERT, '0, bhq_pkg::ID_W'(1));
    push_req(bhq_pkg::CMD_INSERT, bhq_pkg::KEY_W'(16'h8000), bhq_pkg::ID_W'(8'h80));
    push_req(bhq_pkg::CMD_INSERT, '1, bhq_pkg::ID_W'(8'h7f));
    push_req(bhq_pkg::CMD_INSERT, bhq_pkg::KEY_W'(1), bhq_pkg::ID_W'(8'h55));
    push_req(bhq_pkg::CMD_PEEK, '1, '1);
    push_req(CMD_UNUSED, '0, '0);
    repeat (6) push_req(bhq_pkg::CMD_POP, '0, '0);
    push_req(bhq_pkg::CMD_POP, '0, '0);
    push_req(bhq_pkg::CMD_PEEK, '0, '0);
    // equal keys through insert and pop sifting
    push_req(bhq_pkg::CMD_INSERT, bhq_pkg::KEY_W'(5), bhq_pkg::ID_W'(1));
    push_req(bhq_pkg::CMD_INSERT, bhq_pkg::KEY_W'(5), bhq_pkg::ID_W'(2));
    push_req(bhq_pkg::CMD_INSERT, bhq_pkg::KEY_W'(5), bhq_pkg::ID_W'(3));
    repeat (3) push_req(bhq_pkg::CMD_POP, '0, '0);

    // phase 1: fill past capacity, drain past empty, then mixed traffic
    queue_burst(70, 100);
    queue_burst(100, 0);
    queue_random(160);
    wait_drained();

    // phase 2: idle rates swapped
    send_gap_pct = 66;
    recv_gap_pct = 27;
    queue_random(340);
    wait_drained();

    // phase 3: no idling on either side
    send_gap_pct = 0;
    recv_gap_pct = 0;
    queue_random(340);
    wait_drained();

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Summary: %0d inserts (%0d dropped on full), %0d pops, %0d peeks, %0d unused",
             n_insert, n_full, n_pop, n_peek, n_unused);
    $display("Summary: %0d requests hit an empty heap, peak fill %0d of %0d",
             n_empty, peak_fill, bhq_pkg::CAPACITY);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
